FILE: rtl/core/lsp_pkg.sv
// lsp_pkg: shared types, codes and sizes for the lifo stack with peek
// used by the channel interfaces, controller, datapath and top level
// no dependencies
`default_nettype none

package lsp_pkg;

  // built stack depth, default for the top-level parameter
  localparam int DEPTH_DEF = 16;

  // fixed field widths
  localparam int REQ_W  = 2;
  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 5;

  // configuration port
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_TOP  = 2'd3
  } req_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_t;

  // controller to datapath command
  typedef struct packed {
    logic capture;
  } lsp_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/lsp_in_if.sv
// lsp_in_if: request channel (valid/ready plus request word)
// depends on lsp_pkg
`default_nettype none

interface lsp_in_if;
  import lsp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [WORD_W-1:0] push_value;
  logic [POS_W-1:0]        position;

  modport source (output valid, req_type, push_value, position, input ready);
  modport sink   (input valid, req_type, push_value, position, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lsp_out_if.sv
// lsp_out_if: result channel (valid/ready plus result word)
// depends on lsp_pkg
`default_nettype none

interface lsp_out_if;
  import lsp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] data;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         count;
  logic                     full_res;
  logic                     empty_res;

  modport source (output valid, data, status, count, full_res, empty_res, input ready);
  modport sink   (input valid, data, status, count, full_res, empty_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lifo_stack_with_peek.sv
// lifo_stack_with_peek: top level of the lifo stack with peek
// depends on lsp_pkg, lsp_in_if, lsp_out_if, lsp_ctrl, lsp_dpath
//
// usage:
//   in_ch carries one request word: push, pop, peek at a position from the
//   top (1 is the top) or read top. out_ch returns one result word for each
//   request: data (-1 on push and on any failure), status, count after the
//   request, full and empty flags.
//   the capacity register (byte address 0) sets the entries in use; 0 acts
//   as 1 and values above DEPTH act as DEPTH. write it only while idle.
// timing:
//   a request is taken when valid and ready meet; its result is offered from the next
//   cycle, read from the entry ram's registered port. one request at a
//   time: no new request is taken until the result has been taken.
// reset and stall:
//   rst_n (synchronous, low) empties the stack and sets capacity to 16; no
//   clearing pass is needed. while out_ch is stalled the result is held
//   and in_ch is not ready.
`default_nettype none

module lifo_stack_with_peek #(
  parameter int DEPTH = lsp_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lsp_in_if.sink                             in_ch,
  lsp_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lsp_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [lsp_pkg::PDATA_W-1:0]   pwdata,
  output logic      [lsp_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import lsp_pkg::*;

  lsp_cmd_t         cmd;
  logic             cap_we;
  logic [CAP_W-1:0] cap_q;

  // configuration port: one register, always ready
  assign pready = 1'b1;
  assign cap_we = psel && penable && pwrite && pready;
  assign prdata = (paddr == '0) ? PDATA_W'(cap_q) : '0;

  lsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  lsp_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .req_type   (in_ch.req_type),
    .push_value (in_ch.push_value),
    .position   (in_ch.position),
    .cap_we     (cap_we),
    .cap_wdata  (pwdata[CAP_W-1:0]),
    .cap_q      (cap_q),
    .res_data   (out_ch.data),
    .res_status (out_ch.status),
    .res_count  (out_ch.count),
    .res_full   (out_ch.full_res),
    .res_empty  (out_ch.empty_res)
  );

endmodule

`default_nettype wire

FILE: rtl/core/lsp_ram.sv
// lsp_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
`default_nettype none

module lsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lsp_ctrl.sv
// lsp_ctrl: request/result sequencing state machine
// depends on lsp_pkg
`default_nettype none

module lsp_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output lsp_pkg::lsp_cmd_t cmd
);
  import lsp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_OUT  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // handshake outputs
  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign cmd.capture = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (cmd.capture) state_nxt = S_OUT;
      S_OUT:  if (out_ready)   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  // a word is never taken in while a result is on offer
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("in_ready and out_valid both high");

  // every captured word offers a result in the next cycle
  a_offer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> out_valid) else $error("no result after capture");

  // a taken result frees the block for the next word
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready) else $error("not ready after result");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lsp_dpath.sv
// lsp_dpath: fill count, capacity register, entry ram and result registers
// depends on lsp_pkg and lsp_ram
`default_nettype none

module lsp_dpath #(
  parameter int DEPTH = lsp_pkg::DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire lsp_pkg::lsp_cmd_t                cmd,
  input  wire logic [lsp_pkg::REQ_W-1:0]        req_type,
  input  wire logic signed [lsp_pkg::WORD_W-1:0] push_value,
  input  wire logic [lsp_pkg::POS_W-1:0]        position,
  input  wire logic                             cap_we,
  input  wire logic [lsp_pkg::CAP_W-1:0]        cap_wdata,
  output logic      [lsp_pkg::CAP_W-1:0]        cap_q,
  output logic signed [lsp_pkg::WORD_W-1:0]     res_data,
  output logic      [lsp_pkg::STAT_W-1:0]       res_status,
  output logic      [lsp_pkg::CNT_W-1:0]        res_count,
  output logic                                  res_full,
  output logic                                  res_empty
);
  import lsp_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CAP_W-1:0]  cap_r;
  status_t           status_r, status_nxt;
  logic              use_ram_r, use_ram_nxt;
  logic              full_r;
  logic [CMPW-1:0]   cnt_ext, pos_ext, cap_ext, eff_cap, slot, cnt_nxt_ext;
  logic [CW-1:0]     cnt_m1;
  logic              wr_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] ram_q;

  assign cnt_ext     = CMPW'(cnt_r);
  assign pos_ext     = CMPW'(position);
  assign cap_ext     = CMPW'(cap_r);
  assign cnt_m1      = cnt_r - CW'(1);
  assign slot        = cnt_ext - pos_ext;
  assign cnt_nxt_ext = CMPW'(cnt_nxt);

  // capacity clamped to 1..DEPTH
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > DEPTH_C) begin
      eff_cap = DEPTH_C;
    end else begin
      eff_cap = cap_ext;
    end
  end

  // request decode
  always_comb begin
    cnt_nxt     = cnt_r;
    status_nxt  = ST_OK;
    use_ram_nxt = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = cnt_m1[AW-1:0];
    case (req_t'(req_type))
      REQ_PUSH: begin
        if (cnt_ext >= eff_cap || cnt_ext >= DEPTH_C) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          wr_en   = cmd.capture;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      REQ_POP: begin
        if (cnt_r == '0) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          cnt_nxt     = cnt_m1;
          use_ram_nxt = 1'b1;
        end
      end
      REQ_PEEK: begin
        rd_addr = slot[AW-1:0];
        if (position == '0 || pos_ext > cnt_ext) begin
          status_nxt = ST_BADPOS;
        end else begin
          use_ram_nxt = 1'b1;
        end
      end
      REQ_TOP: begin
        if (cnt_r == '0) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          use_ram_nxt = 1'b1;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  // entry storage
  lsp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt_r[AW-1:0]),
    .wdata (push_value),
    .re    (cmd.capture),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // fill count and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cap_r <= CAP_RESET;
    end else begin
      if (cmd.capture) cnt_r <= cnt_nxt;
      if (cap_we)      cap_r <= cap_wdata;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status_r  <= status_nxt;
      use_ram_r <= use_ram_nxt;
      full_r    <= (cnt_nxt_ext >= eff_cap);
    end
  end

  assign cap_q      = cap_r;
  assign res_data   = use_ram_r ? ram_q : '1;
  assign res_status = status_r;
  assign res_count  = CNT_W'(cnt_r);
  assign res_full   = full_r;
  assign res_empty  = (cnt_r == '0);

`ifndef SYNTH
  // fill count never passes the built depth
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ext <= DEPTH_C) else $error("fill count above depth");

  // a successful push raises the count by one
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.capture && wr_en) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("push did not advance count");

  // a failed request leaves the count alone
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.capture && status_nxt != ST_OK) |=> $stable(cnt_r))
    else $error("failed request changed count");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
// tb: self-checking bench for lifo_stack_with_peek, a directed table then random words
// depends on lsp_pkg, lsp_in_if, lsp_out_if and the lifo_stack_with_peek rtl
// expected results (typed rows or an in-bench stack predictor) are checked in order
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsp_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam logic [PADDR_W-1:0] CAP_ADDR = '0;
  localparam logic signed [WORD_W-1:0] FAIL_WORD = -32'sd1;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 70;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    status_t                  status;
    logic [CNT_W-1:0]         count;
    logic                     full_res;
    logic                     empty_res;
  } result_t;

  typedef struct {
    bit                 set_cap;
    logic [CAP_W-1:0]   cap;
    req_t               req;
    logic [WORD_W-1:0]  value;
    logic [POS_W-1:0]   pos;
    bit                 typed;
    result_t            want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  lsp_in_if  in_bus ();
  lsp_out_if out_bus ();

  lifo_stack_with_peek u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state: stack contents, fill level and capacity register
  logic signed [WORD_W-1:0] stack_mem [STACK_DEPTH];
  logic [CNT_W-1:0] fill_level;
  logic [CAP_W-1:0] cap_reg;

  result_t pending_results[$];
  int errors;
  int idle_cycles;
  bit steady;

  // directed words: empty-stack failures, extremes, bad positions, capacity corners
  plan_row_t directed_plan [0:22] = '{
    '{1'b0, 5'd0, REQ_TOP,  32'h0000_0000, 5'd0,  1'b1,
      '{FAIL_WORD, ST_UNDERFLOW, 5'd0, 1'b0, 1'b1}},
    '{1'b0, 5'd0, REQ_POP,  32'hFFFF_FFFF, 5'd0,  1'b1,
      '{FAIL_WORD, ST_UNDERFLOW, 5'd0, 1'b0, 1'b1}},
    '{1'b0, 5'd0, REQ_PEEK, 32'h0000_0000, 5'd1,  1'b1,
      '{FAIL_WORD, ST_BADPOS, 5'd0, 1'b0, 1'b1}},
    '{1'b0, 5'd0, REQ_PEEK, 32'h0000_0000, 5'd0,  1'b1,
      '{FAIL_WORD, ST_BADPOS, 5'd0, 1'b0, 1'b1}},
    '{1'b0, 5'd0, REQ_PUSH, 32'h7FFF_FFFF, 5'd16, 1'b1,
      '{FAIL_WORD, ST_OK, 5'd1, 1'b0, 1'b0}},
    '{1'b0, 5'd0, REQ_PUSH, 32'h8000_0000, 5'd31, 1'b1,
      '{FAIL_WORD, ST_OK, 5'd2, 1'b0, 1'b0}},
    '{1'b0, 5'd0, REQ_PUSH, 32'h0000_0000, 5'd0,  1'b0, '0},
    '{1'b0, 5'd0, REQ_PUSH, 32'hFFFF_FFFF, 5'd0,  1'b0, '0},
    '{1'b0, 5'd0, REQ_TOP,  32'h0000_0000, 5'd0,  1'b0, '0},
    '{1'b0, 5'd0, REQ_PEEK, 32'h0000_0000, 5'd1,  1'b0, '0},
    '{1'b0, 5'd0, REQ_PEEK, 32'h0000_0000, 5'd4,  1'b0, '0},
    '{1'b0, 5'd0, REQ_PEEK, 32'h0000_0000, 5'd5,  1'b0, '0},
    '{1'b0, 5'd0, REQ_PEEK, 32'h0000_0000, 5'd16, 1'b0, '0},
    '{1'b0, 5'd0, REQ_POP,  32'h0000_0000, 5'd0,  1'b0, '0},
    '{1'b0, 5'd0, REQ_POP,  32'h0000_0000, 5'd0,  1'b0, '0},
    // capacity dropped below the fill level
    '{1'b1, 5'd1, REQ_PUSH, 32'h1234_5678, 5'd0,  1'b0, '0},
    '{1'b0, 5'd0, REQ_POP,  32'h0000_0000, 5'd0,  1'b0, '0},
    '{1'b0, 5'd0, REQ_PUSH, 32'h0000_0001, 5'd0,  1'b0, '0},
    '{1'b0, 5'd0, REQ_POP,  32'h0000_0000, 5'd0,  1'b0, '0},
    // zero capacity acts as one
    '{1'b1, 5'd0, REQ_PUSH, 32'hA5A5_A5A5, 5'd0,  1'b0, '0},
    '{1'b0, 5'd0, REQ_PUSH, 32'h5A5A_5A5A, 5'd0,  1'b0, '0},
    // capacity above the built depth
    '{1'b1, 5'd31, REQ_POP, 32'h0000_0000, 5'd0,  1'b0, '0},
    '{1'b0, 5'd0, REQ_PEEK, 32'h0000_0000, 5'd1,  1'b0, '0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // expected result of one request, advancing the predicted stack
  function automatic result_t stack_predict(req_t req, logic [WORD_W-1:0] value,
                                            logic [POS_W-1:0] pos);
    result_t r;
    int lim;
    lim = (cap_reg == 0) ? 1 : ((cap_reg > STACK_DEPTH) ? STACK_DEPTH : int'(cap_reg));
    r.data = FAIL_WORD;
    r.status = ST_OK;
    case (req)
      REQ_PUSH: begin
        if (fill_level >= lim) begin
          r.status = ST_OVERFLOW;
        end else begin
          stack_mem[fill_level] = value;
          fill_level = fill_level + 1'b1;
        end
      end
      REQ_POP: begin
        if (fill_level == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          fill_level = fill_level - 1'b1;
          r.data = stack_mem[fill_level];
        end
      end
      REQ_PEEK: begin
        if (pos == 0 || pos > fill_level) begin
          r.status = ST_BADPOS;
        end else begin
          r.data = stack_mem[fill_level - pos];
        end
      end
      default: begin
        if (fill_level == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.data = stack_mem[fill_level - 1'b1];
        end
      end
    endcase
    r.count = fill_level;
    r.full_res = (fill_level >= lim);
    r.empty_res = (fill_level == 0);
    return r;
  endfunction

  // idle length: mostly none or short, a few long, none in steady stretches
  function automatic int gap_len();
    int k;
    if (steady) return 0;
    k = $urandom_range(99);
    if (k < 60) return 0;
    if (k < 88) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // offer one request word and log its expected result on acceptance
  task automatic send_req(req_t req, logic [WORD_W-1:0] value, logic [POS_W-1:0] pos,
                          bit typed, result_t want);
    int n;
    result_t pred;
    n = gap_len();
    if (n > 0) begin
      in_bus.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.req_type   <= req;
    in_bus.push_value <= value;
    in_bus.position   <= pos;
    do @(posedge clk); while (!in_bus.ready);
    pred = stack_predict(req, value, pos);
    pending_results.push_back(typed ? want : pred);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // capacity register write: setup then access cycle
  task automatic cap_write(logic [CAP_W-1:0] cap);
    logic [PDATA_W-1:0] word;
    word = $urandom;
    word[CAP_W-1:0] = cap;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_reg = cap;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random request with push weight; peeks mostly land inside the stack
  task automatic send_random(int push_pct);
    req_t req;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0] pos;
    int k;
    k = $urandom_range(99);
    if (k < push_pct) begin
      req = REQ_PUSH;
    end else begin
      case ($urandom_range(2))
        0: req = REQ_POP;
        1: req = REQ_PEEK;
        default: req = REQ_TOP;
      endcase
    end
    case ($urandom_range(19))
      0: value = 32'h7FFF_FFFF;
      1: value = 32'h8000_0000;
      2: value = 32'h0000_0000;
      3: value = 32'hFFFF_FFFF;
      default: value = $urandom;
    endcase
    if (fill_level > 0 && $urandom_range(99) < 75) begin
      pos = POS_W'($urandom_range(1, fill_level));
    end else begin
      pos = POS_W'($urandom_range(0, 16));
    end
    send_req(req, value, pos, 1'b0, '0);
  endtask

  // sink side: random stalls on ready
  initial begin : result_sink
    int n;
    out_bus.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  // compare each delivered result word with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no request pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_bus.data !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, out_bus.data);
          errors++;
        end
        if (out_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_bus.status);
          errors++;
        end
        if (out_bus.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_bus.count);
          errors++;
        end
        if (out_bus.full_res !== want.full_res) begin
          $error("full_res: expected %0b, got %0b", want.full_res, out_bus.full_res);
          errors++;
        end
        if (out_bus.empty_res !== want.empty_res) begin
          $error("empty_res: expected %0b, got %0b", want.empty_res, out_bus.empty_res);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // main sequence
  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [PHASES];
    int push_pct;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.req_type   = REQ_PUSH;
    in_bus.push_value = '0;
    in_bus.position   = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    errors            = 0;
    idle_cycles       = 0;
    steady            = 1'b0;
    fill_level        = '0;
    cap_reg           = CAP_RESET;
    phase_caps = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd17, 5'd1, 5'd9, 5'd16, 5'd0, 5'd0};
    phase_caps[8] = CAP_W'($urandom_range(0, 31));
    phase_caps[9] = CAP_W'($urandom_range(0, 31));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_plan[i]) begin
      if (directed_plan[i].set_cap) begin
        drain();
        cap_write(directed_plan[i].cap);
      end
      send_req(directed_plan[i].req, directed_plan[i].value, directed_plan[i].pos,
               directed_plan[i].typed, directed_plan[i].want);
    end

    // random phases, each under its own capacity
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      cap_write(phase_caps[ph]);
      steady = (ph == 2 || ph == 7);
      push_pct = (ph % 2 == 0) ? 70 : 35;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // hold off until the result path is empty
        if (ph == 4 && i == PHASE_WORDS / 2) drain();
        send_random(push_pct);
      end
    end

    // wait out the tail
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/lsp_pkg.sv
rtl/core/lsp_in_if.sv
rtl/core/lsp_out_if.sv
rtl/core/lsp_ram.sv
rtl/core/lsp_ctrl.sv
rtl/core/lsp_dpath.sv
rtl/core/lifo_stack_with_peek.sv
test/tb.sv
